// ----- rtl/core/ibs_pkg.sv -----
package ibs_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] value_type;

   // signed ordering used by the partition step
   function automatic logic is_less(input value_type a, input value_type b);
      is_less = (a < b);
   endfunction

endpackage

// ----- rtl/core/integer_block_sorter.sv -----
// loading: a block of n items loads at one item per cycle while req_stall is low, then sorts and emits
// sort: each scanned element is read and compared, a swap writes the store twice, a pop reads the stack
// emission: each result is read, loaded into the output register and held until taken, then the next is read
// the element store serves one access at a time, either a read or a write
// throughput: one block at a time, req_stall stays high from the closing item to the last result
// reset: synchronous, active high; clears count, overflow flag, stack pointer, sequencer, rsp_valid
module integer_block_sorter
   import ibs_pkg::*;
#(
   parameter int SIZE = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  value_type        req_value,
   input  logic             req_last,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output value_type        rsp_sorted_value,
   output logic             rsp_last_out,
   output logic             rsp_overflow
);

   // index into the store, and a count wide enough to hold SIZE itself
   localparam int IW = $clog2(SIZE);
   localparam int CW = $clog2(SIZE + 1);
   localparam logic [CW-1:0] SIZE_C = CW'(SIZE);
   localparam logic [CW-1:0] ONE_C  = CW'(1);
   localparam logic [CW-1:0] TWO_C  = CW'(2);

   // sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_START     = 4'd1;
   localparam logic [3:0] S_POP       = 4'd2;
   localparam logic [3:0] S_POP_WAIT  = 4'd3;
   localparam logic [3:0] S_RANGE     = 4'd4;
   localparam logic [3:0] S_PIVOT     = 4'd5;
   localparam logic [3:0] S_SCAN      = 4'd6;
   localparam logic [3:0] S_CMP       = 4'd7;
   localparam logic [3:0] S_SWAP_A    = 4'd8;
   localparam logic [3:0] S_SWAP_B    = 4'd9;
   localparam logic [3:0] S_FIN_A     = 4'd10;
   localparam logic [3:0] S_FIN_B     = 4'd11;
   localparam logic [3:0] S_SPLIT     = 4'd12;
   localparam logic [3:0] S_EMIT_RD   = 4'd13;
   localparam logic [3:0] S_EMIT_LOAD = 4'd14;
   localparam logic [3:0] S_EMIT_WAIT = 4'd15;

   // element store and range stack, both single write / single read, registered read
   value_type          store_mem [SIZE];
   logic [2*IW-1:0]    stack_mem [SIZE];

   // control state
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // working indices, all count-wide since p + 1 can reach SIZE
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] p_ff, p_in;
   logic [CW-1:0] k_ff, k_in;

   // datapath registers
   value_type     pivot_ff, pivot_in;
   value_type     a_ff, a_in;
   value_type     rdata_ff;
   logic [2*IW-1:0] stk_rdata_ff;
   value_type     rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   // store and stack port controls
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   value_type     mem_wdata;
   logic          mem_re;
   logic [IW-1:0] mem_raddr;
   logic          stk_we;
   logic [IW-1:0] stk_waddr;
   logic [2*IW-1:0] stk_wdata;
   logic          stk_re;
   logic [IW-1:0] stk_raddr;

   // partition split helpers
   logic [CW-1:0] left_len;
   logic [CW-1:0] right_len;
   logic [CW-1:0] p_plus1;
   logic [CW-1:0] p_minus1;
   logic [CW-1:0] cnt_last;
   logic          sp_room;

   assign left_len  = p_ff - lo_ff;
   assign right_len = hi_ff - p_ff;
   assign p_plus1   = p_ff + ONE_C;
   assign p_minus1  = p_ff - ONE_C;
   assign cnt_last  = count_ff - ONE_C;
   assign sp_room   = (sp_ff < SIZE_C);

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      sp_in        = sp_ff;
      rsp_valid_in = rsp_valid_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      p_in         = p_ff;
      k_in         = k_ff;
      pivot_in     = pivot_ff;
      a_in         = a_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[IW-1:0];
      mem_wdata    = req_value;
      mem_re       = 1'b0;
      mem_raddr    = i_ff[IW-1:0];
      stk_we       = 1'b0;
      stk_waddr    = sp_ff[IW-1:0];
      stk_wdata    = {p_plus1[IW-1:0], hi_ff[IW-1:0]};
      stk_re       = 1'b0;
      stk_raddr    = sp_ff[IW-1:0] - IW'(1);

      case (state_ff)
         S_IDLE: begin
            // load phase: store while room is left, else drop and flag
            if (req_valid) begin
               if (count_ff < SIZE_C) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + ONE_C;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            sp_in = '0;
            k_in  = '0;
            if (count_ff < TWO_C) begin
               state_in = S_EMIT_RD;
            end else begin
               // the whole block is the first range, taken without a push
               lo_in    = '0;
               hi_in    = cnt_last;
               state_in = S_RANGE;
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               k_in     = '0;
               state_in = S_EMIT_RD;
            end else begin
               stk_re   = 1'b1;
               sp_in    = sp_ff - ONE_C;
               state_in = S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            lo_in    = CW'(stk_rdata_ff[2*IW-1:IW]);
            hi_in    = CW'(stk_rdata_ff[IW-1:0]);
            state_in = S_RANGE;
         end
         S_RANGE: begin
            if (lo_ff < hi_ff) begin
               // fetch the pivot from the top of the range
               mem_re    = 1'b1;
               mem_raddr = hi_ff[IW-1:0];
               p_in      = lo_ff;
               i_in      = lo_ff;
               state_in  = S_PIVOT;
            end else begin
               state_in = S_POP;
            end
         end
         S_PIVOT: begin
            pivot_in = rdata_ff;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            mem_re = 1'b1;
            if (i_ff < hi_ff) begin
               mem_raddr = i_ff[IW-1:0];
               state_in  = S_CMP;
            end else begin
               // scan done, fetch the boundary element for the pivot swap
               mem_raddr = p_ff[IW-1:0];
               state_in  = S_FIN_A;
            end
         end
         S_CMP: begin
            a_in = rdata_ff;
            if (is_less(rdata_ff, pivot_ff)) begin
               if (i_ff == p_ff) begin
                  p_in     = p_ff + ONE_C;
                  i_in     = i_ff + ONE_C;
                  state_in = S_SCAN;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = p_ff[IW-1:0];
                  state_in  = S_SWAP_A;
               end
            end else begin
               i_in     = i_ff + ONE_C;
               state_in = S_SCAN;
            end
         end
         S_SWAP_A: begin
            mem_we    = 1'b1;
            mem_waddr = p_ff[IW-1:0];
            mem_wdata = a_ff;
            state_in  = S_SWAP_B;
         end
         S_SWAP_B: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff[IW-1:0];
            mem_wdata = rdata_ff;
            p_in      = p_ff + ONE_C;
            i_in      = i_ff + ONE_C;
            state_in  = S_SCAN;
         end
         S_FIN_A: begin
            mem_we    = 1'b1;
            mem_waddr = hi_ff[IW-1:0];
            mem_wdata = rdata_ff;
            state_in  = S_FIN_B;
         end
         S_FIN_B: begin
            mem_we    = 1'b1;
            mem_waddr = p_ff[IW-1:0];
            mem_wdata = pivot_ff;
            state_in  = S_SPLIT;
         end
         S_SPLIT: begin
            // push the larger side if the stack has room, keep working on the smaller one
            if (left_len < right_len) begin
               if ((p_plus1 < hi_ff) && sp_room) begin
                  stk_we    = 1'b1;
                  stk_wdata = {p_plus1[IW-1:0], hi_ff[IW-1:0]};
                  sp_in     = sp_ff + ONE_C;
               end
               if (p_ff == lo_ff) begin
                  state_in = S_POP;
               end else begin
                  hi_in    = p_minus1;
                  state_in = S_RANGE;
               end
            end else begin
               if ((p_ff > (lo_ff + ONE_C)) && sp_room) begin
                  stk_we    = 1'b1;
                  stk_wdata = {lo_ff[IW-1:0], p_minus1[IW-1:0]};
                  sp_in     = sp_ff + ONE_C;
               end
               lo_in    = p_plus1;
               state_in = S_RANGE;
            end
         end
         S_EMIT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = k_ff[IW-1:0];
            state_in  = S_EMIT_LOAD;
         end
         S_EMIT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rdata_ff;
            rsp_last_in  = (k_ff == cnt_last);
            rsp_ovf_in   = ovf_ff;
            state_in     = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  // block closed, ready for the next one
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + ONE_C;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers, no reset needed
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      i_ff         <= i_in;
      p_ff         <= p_in;
      k_ff         <= k_in;
      pivot_ff     <= pivot_in;
      a_ff         <= a_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // element store, read data held until the next read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= store_mem[mem_raddr];
      end
   end

   // range stack of pending (lo, hi) pairs
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rdata_ff <= stack_mem[stk_raddr];
      end
   end

   // the stored count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SIZE_C)
      else $error("element count beyond store depth");

   // the stack pointer never passes the stack depth
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SIZE_C)
      else $error("range stack overrun");

   // the boundary index never runs ahead of the scan index
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (p_ff <= i_ff))
      else $error("partition boundary ahead of scan");

   // once the final result is taken, the block state is cleared and loading resumes
   a_block_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_out) |=>
         ((count_ff == '0) && !ovf_ff && (state_ff == S_IDLE)))
      else $error("block not cleared after final result");

endmodule
